[sv/binary_to_decimal_ascii_top_macros.svh]
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define B2DASC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b2dasc assertion failed");

// Next-cycle implication, checked on clk, off while arst_n is low.
`define B2DASC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b2dasc assertion failed");

`endif

[sv/b2dasc_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps
package b2dasc_pkg;

	localparam int FIELD_BITS     = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_MOVE
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       bit_in;
	} chain_ctrl_t;

endpackage

[sv/b2dasc_cell.sv]
// One BCD digit cell: add-3 and shift during conversion, digit move during output.
`timescale 1ns / 1ps
module b2dasc_cell (
	input  logic                          clk,
	input  b2dasc_pkg::cell_mode_t        mode,
	input  logic                          bit_in,
	output logic                          bit_out,
	input  logic [b2dasc_pkg::DIGIT_W-1:0] digit_in,
	output logic [b2dasc_pkg::DIGIT_W-1:0] digit
);
	import b2dasc_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// correct the digit before it doubles so it never passes nine
	assign adj     = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (mode)
			CELL_CLEAR:  digit_q <= '0;
			CELL_DABBLE: digit_q <= {adj[DIGIT_W-2:0], bit_in};
			CELL_MOVE:   digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

[sv/b2dasc_chain.sv]
// Row of BCD digit cells, least significant digit at cell 0.
`timescale 1ns / 1ps
module b2dasc_chain #(
	parameter int NUM_DIGITS = 10
) (
	input  logic                           clk,
	input  b2dasc_pkg::chain_ctrl_t         ctrl,
	output logic [b2dasc_pkg::DIGIT_W-1:0] top_digit
);
	import b2dasc_pkg::*;

	logic [NUM_DIGITS:0]  carry;
	logic [DIGIT_W-1:0]   digits [NUM_DIGITS+1];

	assign carry[0]  = ctrl.bit_in;
	// bottom cell takes zeros while digits move up
	assign digits[0] = '0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		b2dasc_cell u_cell (
			.clk      (clk),
			.mode     (ctrl.mode),
			.bit_in   (carry[i]),
			.bit_out  (carry[i+1]),
			.digit_in (digits[i]),
			.digit    (digits[i+1])
		);
	end

	assign top_digit = digits[NUM_DIGITS];

endmodule

[sv/binary_to_decimal_ascii_top.sv]
// Operation: the value is accepted in idle, then shifted into the cell row bit by bit, MSB first (32 bits by default).
// Output: the digit positions (10 by default) are shifted out in turn; leading zeros are shifted out silently.
// A new value is taken only after the last character of the previous one transfers.
// Reset (arst_n, asynchronous, active low) returns the controller to idle; digits need no reset.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_top_macros.svh"
module binary_to_decimal_ascii_top #(
	parameter int VALUE_BITS = b2dasc_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [b2dasc_pkg::FIELD_BITS-1:0] s_tdata,  // [31:0] value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic                              m_tlast   // last digit of the number
);
	import b2dasc_pkg::*;

	localparam int EFF_BITS   = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int NUM_DIGITS = (EFF_BITS * 30103) / 100000 + 1;
	localparam int CNT_W      = $clog2(EFF_BITS);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	state_t              state_q, state_d;
	logic [EFF_BITS-1:0] value_q;
	logic [CNT_W-1:0]    bit_cnt_q;
	logic [REM_W-1:0]    rem_q;
	logic                started_q;
	logic [DIGIT_W-1:0]  top_digit;
	logic                emit_vld;
	logic                advance;
	logic                in_xfer;
	chain_ctrl_t         ctrl;

	assign in_xfer  = s_tvalid && s_tready;
	assign emit_vld = started_q || (top_digit != '0) || (rem_q == REM_W'(1));
	assign advance  = !emit_vld || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_SHIFT;
			ST_SHIFT: if (bit_cnt_q == '0) state_d = ST_EMIT;
			ST_EMIT:  if (advance && rem_q == REM_W'(1)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		ctrl.mode   = CELL_HOLD;
		ctrl.bit_in = value_q[EFF_BITS-1];
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ctrl.mode = CELL_CLEAR;
			end
			ST_SHIFT: ctrl.mode = CELL_DABBLE;
			ST_EMIT: begin
				m_tvalid = emit_vld;
				if (advance) ctrl.mode = CELL_MOVE;
			end
			default: ctrl.mode = CELL_HOLD;
		endcase
	end

	assign m_tdata = {2'b00, ASCII_ZERO + CHAR_W'(top_digit)};
	assign m_tlast = (rem_q == REM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					bit_cnt_q <= CNT_W'(EFF_BITS - 1);
				end
				ST_SHIFT: begin
					bit_cnt_q <= bit_cnt_q - CNT_W'(1);
					rem_q     <= REM_W'(NUM_DIGITS);
					started_q <= 1'b0;
				end
				ST_EMIT: begin
					if (advance) begin
						rem_q <= rem_q - REM_W'(1);
						if (emit_vld) started_q <= 1'b1;
					end
				end
				default: begin
					bit_cnt_q <= bit_cnt_q;
				end
			endcase
		end
	end

	// value shift register feeds the cell row MSB first
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q <= s_tdata[EFF_BITS-1:0];
		end else if (state_q == ST_SHIFT) begin
			value_q <= value_q << 1;
		end
	end

	b2dasc_chain #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.top_digit (top_digit)
	);

	`B2DASC_ASSERT_NOW(a_char_is_digit, m_tvalid, m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57)
	`B2DASC_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready)
	`B2DASC_ASSERT_NEXT(a_last_ends_run, m_tvalid && m_tready && m_tlast, state_q == ST_IDLE)
	`B2DASC_ASSERT_NEXT(a_accept_starts, in_xfer, state_q == ST_SHIFT && bit_cnt_q == CNT_W'(EFF_BITS - 1))

endmodule

[bench/tb_top.sv]
// Testbench for the binary to decimal ASCII converter: directed table, random values, scoreboard.
`timescale 1ns / 1ps
module tb_top;

	localparam int VALUE_W      = b2dasc_pkg::FIELD_BITS;
	localparam int CONV_BITS    = b2dasc_pkg::VALUE_BITS_DEF;
	localparam int RANDOM_ITEMS = 448;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TABLE_ROWS   = 22;

	typedef struct packed {
		logic [b2dasc_pkg::CHAR_W-1:0] digit_char;
		logic                          last;
	} ascii_char_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;
	logic               m_tlast;

	ascii_char_t expected_chars[$];
	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned values_sent;
	int unsigned chars_checked = 0;
	int unsigned burst_left;
	logic [15:0] ready_pattern;

	// Directed values; a non-empty text is the expected decimal string, typed in by hand.
	logic [VALUE_W-1:0] table_value [TABLE_ROWS] = '{
		32'd0, 32'd4294967295, 32'd2147483648, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99,
		32'd100, 32'd101, 32'd1000, 32'd65535, 32'd65536, 32'd999999999,
		32'd1000000000, 32'd1000000001, 32'h55555555, 32'hAAAAAAAA, 32'd4000000000,
		32'd1234567890, 32'd987654321, 32'd0
	};
	string table_text [TABLE_ROWS] = '{
		"0", "4294967295", "2147483648", "", "", "", "", "",
		"", "", "", "", "", "",
		"", "", "", "", "",
		"", "", "0"
	};

	binary_to_decimal_ascii_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decimal digits of the converted value, most significant first, last flag on the final one.
	function automatic void queue_decimal(input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] rest;
		logic [3:0]         digits [10];
		int                 count;
		ascii_char_t        ch;
		rest  = value & ({VALUE_W{1'b1}} >> (VALUE_W - CONV_BITS));
		count = 0;
		do begin
			digits[count] = 4'(rest % 10);
			rest = rest / 10;
			count++;
		end while (rest != 0);
		for (int k = count - 1; k >= 0; k--) begin
			ch.digit_char = b2dasc_pkg::ASCII_ZERO + 6'(digits[k]);
			ch.last       = (k == 0);
			expected_chars.push_back(ch);
		end
	endfunction

	// Present one value, keeping tvalid high inside a burst, and record its characters on transfer.
	task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
		ascii_char_t ch;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		values_sent++;
		if (text.len() == 0) begin
			queue_decimal(value);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				ch.digit_char = 6'(text[i]);
				ch.last       = (i == text.len() - 1);
				expected_chars.push_back(ch);
			end
		end
	endtask

	// Receiver: rotate a stall pattern, reloaded now and then; some windows never stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_pattern <= 16'hFFFF;
			m_tready      <= 1'b0;
		end else begin
			if (cycle_count[5:0] == 6'd0)
				ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
			else
				ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
			m_tready <= ready_pattern[15];
		end
	end

	// Compare each output transfer against the oldest expected character.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character, actual tdata %h last %b",
					$time, m_tdata, m_tlast);
				error_count++;
			end else begin
				ascii_char_t exp_ch;
				exp_ch = expected_chars.pop_front();
				chars_checked++;
				if (m_tdata !== {2'b00, exp_ch.digit_char} || m_tlast !== exp_ch.last) begin
					$display("%0t: character mismatch, expected tdata %h last %b, %s %h last %b",
						$time, {2'b00, exp_ch.digit_char}, exp_ch.last, "actual tdata",
						m_tdata, m_tlast);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d characters outstanding", $time, expected_chars.size());
			$display("binary_to_decimal_ascii_top test failed");
			$finish;
		end
	end

	initial begin
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] power;
		int unsigned        mode;
		values_sent   = 0;
		burst_left    = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < TABLE_ROWS; row++)
			send_value(table_value[row], table_text[row]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				// land next to a power of ten, where the digit count changes
				power = 1;
				repeat ($urandom_range(0, 9)) power = power * 10;
				value = power + $urandom_range(0, 2) - 1;
			end else if (mode <= 2) begin
				value = $urandom;
			end else begin
				value = $urandom >> $urandom_range(0, 31);
			end
			send_value(value, "");
		end
		s_tvalid <= 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d directed, %0d random), %0d characters checked.",
			values_sent, TABLE_ROWS, RANDOM_ITEMS, chars_checked);
		$display("Input bursts and output stalls varied; %0d mismatches seen.", error_count);
		if (error_count == 0)
			$display("binary_to_decimal_ascii_top test passed");
		else
			$display("binary_to_decimal_ascii_top test failed");
		$finish;
	end

endmodule
